[design/sks_pkg.sv]
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types and fixed field widths for the streaming k-th smallest block.
// ----------------------------------------------------------------------------
package sks_pkg;

    // Fixed widths of the port fields
    localparam int SAMPLE_W = 32;
    localparam int RESULT_W = 32;
    localparam int RANK_W   = 5;

    // Per-cell control from the top level
    typedef struct packed {
        logic load;   // take the broadcast sample this cycle
        logic clear;  // return to the empty marker
        logic keep;   // cell index is below the active rank
    } sks_ctrl_t;

endpackage

[design/sks_cell.sv]
// ----------------------------------------------------------------------------
// sks_cell
// One entry of the sorted store: compares the broadcast sample with its own
// value and, on an insert, takes either the sample or its left neighbor.
// ----------------------------------------------------------------------------
module sks_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sks_pkg::sks_ctrl_t     ctrl,
    input  logic [VALUE_WIDTH-1:0] sample,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic                   left_gt,
    output logic [VALUE_WIDTH-1:0] value,
    output logic                   gt
);

    localparam logic [VALUE_WIDTH-1:0] EMPTY = {VALUE_WIDTH{1'b1}};

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;

    // strict compare: equal values stay in place
    assign gt    = value_reg > sample;
    assign value = value_reg;

    // insert: shift right where the left cell is also larger
    always_comb begin
        value_next = value_reg;
        if (ctrl.clear) begin
            value_next = EMPTY;
        end else if (ctrl.load) begin
            if (!ctrl.keep) begin
                value_next = EMPTY;
            end else if (gt) begin
                value_next = left_gt ? left_value : sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= EMPTY;
        end else begin
            value_reg <= value_next;
        end
    end

endmodule

[design/streaming_kth_smallest_top.sv]
// ----------------------------------------------------------------------------
// streaming_kth_smallest_top
// Keeps the k smallest values of a stream in a sorted chain of cells and
// reports the k-th smallest after the last value of the stream arrives.
// ----------------------------------------------------------------------------
//  channel  | direction | ports
//  ---------+-----------+------------------------------------------------
//  s_       | in        | s_valid, s_ready, s_sample_value, s_end_of_stream
//  m_       | out       | m_valid, m_ready, m_kth_value, m_too_few
//  cfg_     | in        | cfg_wr_en, cfg_wr_data (select_rank)
//
//  A value enters every cycle while s_ready is high; each cell compares and
//  shifts as the value is taken. A request marked end of stream starts a
//  flush: the store is read at rank k into the output register and cleared,
//  with s_ready low. The flush waits while a previous result is held on m_.
//  Synchronous active-low reset empties the store and sets the rank to 1.
// ----------------------------------------------------------------------------
module streaming_kth_smallest_top #(
    parameter int MAX_RANK    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sks_pkg::RANK_W-1:0]      cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sks_pkg::SAMPLE_W-1:0]    s_sample_value,
    input  logic                            s_end_of_stream,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sks_pkg::RESULT_W-1:0]    m_kth_value,
    output logic                            m_too_few
);

    localparam int CNT_W   = $clog2(MAX_RANK + 1);
    localparam int IDX_W   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CMP_W   = (CNT_W > sks_pkg::RANK_W) ? CNT_W : sks_pkg::RANK_W;
    localparam logic [VALUE_WIDTH-1:0] EMPTY = {VALUE_WIDTH{1'b1}};

    logic [sks_pkg::RANK_W-1:0]  rank_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        flush_reg;
    logic                        m_valid_reg;
    logic [sks_pkg::RESULT_W-1:0] kth_reg;
    logic                        too_few_reg;

    logic [CMP_W-1:0]            rank_wide;
    logic [CMP_W-1:0]            rank_eff;
    logic [CNT_W-1:0]            rank_k;
    logic [CNT_W-1:0]            rank_m1;
    logic                        accept;
    logic                        out_free;
    logic                        do_flush;
    logic [VALUE_WIDTH-1:0]      sample;

    sks_pkg::sks_ctrl_t          cell_ctrl  [MAX_RANK];
    logic [VALUE_WIDTH-1:0]      cell_value [MAX_RANK];
    logic                        cell_gt    [MAX_RANK];

    // effective rank: zero acts as one, large values clamp to MAX_RANK
    assign rank_wide = CMP_W'(rank_reg);
    always_comb begin
        priority if (rank_wide == '0) begin
            rank_eff = CMP_W'(1);
        end else if (rank_wide > CMP_W'(MAX_RANK)) begin
            rank_eff = CMP_W'(MAX_RANK);
        end else begin
            rank_eff = rank_wide;
        end
    end
    assign rank_k  = CNT_W'(rank_eff);
    assign rank_m1 = rank_k - CNT_W'(1);

    // handshake
    assign s_ready  = !flush_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign do_flush = flush_reg && out_free;
    assign sample   = VALUE_WIDTH'(s_sample_value);

    // count: grows up to k, cut back to k if the rank was lowered
    assign count_next = (count_reg < rank_k) ? count_reg + CNT_W'(1) : rank_k;

    // chain of cells
    for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
        assign cell_ctrl[i].load  = accept;
        assign cell_ctrl[i].clear = do_flush;
        assign cell_ctrl[i].keep  = CMP_W'(i) < rank_eff;

        if (i == 0) begin : g_head
            sks_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl[i]),
                .sample     (sample),
                .left_value (EMPTY),
                .left_gt    (1'b0),
                .value      (cell_value[i]),
                .gt         (cell_gt[i])
            );
        end else begin : g_body
            sks_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl[i]),
                .sample     (sample),
                .left_value (cell_value[i-1]),
                .left_gt    (cell_gt[i-1]),
                .value      (cell_value[i]),
                .gt         (cell_gt[i])
            );
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg    <= sks_pkg::RANK_W'(1);
            count_reg   <= '0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                rank_reg <= cfg_wr_data;
            end
            if (do_flush) begin
                count_reg <= '0;
            end else if (accept) begin
                count_reg <= count_next;
            end
            if (accept && s_end_of_stream) begin
                flush_reg <= 1'b1;
            end else if (do_flush) begin
                flush_reg <= 1'b0;
            end
            if (do_flush) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result register: read the store at rank k
    always_ff @(posedge aclk) begin
        if (do_flush) begin
            if (count_reg < rank_k) begin
                kth_reg     <= {sks_pkg::RESULT_W{1'b1}};
                too_few_reg <= 1'b1;
            end else begin
                kth_reg     <= sks_pkg::RESULT_W'(cell_value[rank_m1[IDX_W-1:0]]);
                too_few_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kth_value = kth_reg;
    assign m_too_few   = too_few_reg;

    // assertions
    a_last_flush : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_stream) |=> flush_reg)
        else $error("end of stream did not start a flush");

    a_flush_done : assert property (@(posedge aclk) disable iff (!aresetn)
        do_flush |=> (count_reg == '0 && m_valid_reg && !flush_reg))
        else $error("flush did not clear store and present result");

    a_count_max : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_RANK))
        else $error("kept count beyond store depth");

    for (genvar j = 1; j < MAX_RANK; j++) begin : g_sorted
        a_sorted : assert property (@(posedge aclk) disable iff (!aresetn)
            cell_value[j-1] <= cell_value[j])
            else $error("store out of order");
    end

endmodule
